// ===== rtl/assert_macros.svh =====
// shared assertion macros for the meter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define SMAM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define SMAM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/smam_pkg.sv =====
// ----------------------------------------------------------------------------
// smam_pkg
// Widths, register indexes and shared types of the scaled moving average meter.
// ----------------------------------------------------------------------------
package smam_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int VREF_W      = 16;
  localparam int GAIN_W      = 16;
  localparam int WIN_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MV_W        = 24;
  localparam int SUM_W       = 30;
  localparam int MAX_WINDOW  = 64;
  localparam int SLOT_W      = 6;

  // gain is Q8.8, code is a fraction of 2^SAMPLE_BITS
  localparam int SCALE_SHIFT = SAMPLE_BITS + 8;
  localparam int MUL_A_W     = SAMPLE_BITS + VREF_W;
  localparam int PROD_W      = MUL_A_W + GAIN_W;

  // divider: quotient always fits the output width
  localparam int DIV_STEPS   = MV_W;
  localparam int DIV_CNT_W   = 5;
  localparam int REM_W       = WIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_VREF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic [VREF_W-1:0] VREF_RESET   = 16'd3300;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd256;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 7'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/smam_div.sv =====
// ----------------------------------------------------------------------------
// smam_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smam_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [smam_pkg::SUM_W-1:0]           dividend_i,
  input  logic [smam_pkg::WIN_W-1:0]           divisor_i,
  output logic [smam_pkg::MV_W-1:0]            quotient_o,
  output smam_pkg::div_status_t                status_o
);
  import smam_pkg::*;

  logic [REM_W-1:0]     rem_q, rem_d;
  logic [MV_W-1:0]      quo_q, quo_d;
  logic [WIN_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [REM_W:0]   shifted;
  logic [REM_W+1:0] diff;

  assign shifted = {rem_q, quo_q[MV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // sum < fill * 2^24, so the top bits are already below the divisor
      rem_d  = {1'b0, dividend_i[SUM_W-1:MV_W]};
      quo_d  = dividend_i[MV_W-1:0];
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[REM_W+1]) begin
        rem_d = diff[REM_W-1:0];
        quo_d = {quo_q[MV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[REM_W-1:0];
        quo_d = {quo_q[MV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== rtl/scaled_moving_average_meter.sv =====
// An accepted item passes MUL1, MUL2, SCALE, DIV and DONE to the output register.
// A new item is stalled until the meter is idle again; each item takes two passes
// through the shared multiplier, the ring update and the 24 radix-2 divider steps.
// The output register lets a new item in while a result still waits to be taken.
// Reset (async, active low) restores the register defaults and empties the filter;
// the sample ring itself is not cleared, the fill count keeps unwritten slots unread.
// ----------------------------------------------------------------------------
// scaled_moving_average_meter
// One meter channel: scales converter codes to millivolts and averages them
// over a configurable window with a running sum.
// ----------------------------------------------------------------------------
module scaled_moving_average_meter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [smam_pkg::SAMPLE_BITS-1:0]   raw_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [smam_pkg::MV_W-1:0]          average_millivolts_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [smam_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [smam_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import smam_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_MUL2  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [VREF_W-1:0] vref_q;
  logic [GAIN_W-1:0] gain_q;
  logic [WIN_W-1:0]  window_q;

  logic [SAMPLE_BITS-1:0] raw_q;
  logic [PROD_W-1:0]      prod_q;
  logic [MV_W-1:0]        old_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [WIN_W-1:0]       fill_q, fill_d;
  logic [SLOT_W-1:0]      oldest_q, oldest_d;
  logic                   out_valid_q;
  logic [MV_W-1:0]        out_data_q;

  logic [MV_W-1:0] ring_mem [MAX_WINDOW];

  logic                 in_acc, out_take, cfg_acc, out_free;
  logic [WIN_W-1:0]     eff_win;
  logic                 full;
  logic [SLOT_W-1:0]    slot;
  logic [WIN_W-1:0]     next_oldest;
  logic [MUL_A_W-1:0]   mul_a;
  logic [GAIN_W-1:0]    mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [MV_W-1:0]      scaled;
  logic                 ring_we;
  logic                 div_start;
  logic [MV_W-1:0]      div_quo;
  div_status_t          div_st;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // zero means one, above the ring size saturates
  always_comb begin
    if (window_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_q > WIN_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = window_q;
    end
  end

  assign full        = (fill_q >= eff_win);
  assign slot        = full ? oldest_q : fill_q[SLOT_W-1:0];
  assign next_oldest = WIN_W'(oldest_q) + 1'b1;

  // shared multiplier: code * vref first, then that product * gain
  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_a = MUL_A_W'(raw_q);
      mul_b = vref_q;
    end else begin
      mul_a = prod_q[MUL_A_W-1:0];
      mul_b = gain_q;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // the full-scale product shifted down always fits 24 bits
  assign scaled = prod_q[PROD_W-1:SCALE_SHIFT];

  assign ring_we   = (state_q == ST_SCALE);
  assign div_start = (state_q == ST_SCALE);

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    fill_d   = fill_q;
    oldest_d = oldest_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_SCALE;
      ST_SCALE: begin
        if (full) begin
          sum_d    = sum_q - SUM_W'(old_q) + SUM_W'(scaled);
          oldest_d = (next_oldest == eff_win) ? '0 : next_oldest[SLOT_W-1:0];
        end else begin
          sum_d    = sum_q + SUM_W'(scaled);
          fill_d   = fill_q + 1'b1;
          oldest_d = '0;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a window write empties the filter
    if (cfg_acc && cfg_index_i == REG_WINDOW) begin
      sum_d    = '0;
      fill_d   = '0;
      oldest_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vref_q      <= VREF_RESET;
      gain_q      <= GAIN_RESET;
      window_q    <= WINDOW_RESET;
      sum_q       <= '0;
      fill_q      <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_VREF:   vref_q   <= cfg_data_i[VREF_W-1:0];
          REG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
          REG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q <= raw_sample_i;
    end
    if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= div_quo;
    end
  end

  // sample ring, registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot] <= scaled;
    end
    if (state_q == ST_MUL2) begin
      old_q <= ring_mem[slot];
    end
  end

  smam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  assign out_valid_o          = out_valid_q;
  assign average_millivolts_o = out_data_q;

  `SMAM_ASSERT(a_fill_bounded, fill_q <= WIN_W'(MAX_WINDOW))
  `SMAM_ASSERT(a_oldest_only_when_full, (oldest_q != '0) |-> (fill_q == eff_win))
  `SMAM_ASSERT(a_sum_bounded,
               (fill_q == '0) ? (sum_q == '0) : (sum_q < ((SUM_W+1)'(fill_q) << MV_W)))
  `SMAM_ASSERT(a_result_after_divide, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
  `SMAM_ASSERT(a_div_busy_in_div, div_st.busy |-> (state_q == ST_DIV))
  `SMAM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o)

endmodule
